[rtl/hll_pkg.sv]
`default_nettype none

package hll_pkg;

    // Multiplier, seed and shift of the 64-bit multiply-xorshift hash.
    localparam logic [63:0] HLL_MULT  = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] HLL_SEED  = 64'h00000000cafebabe;
    localparam int          HLL_SHIFT = 47;

    // The hash always covers eight bytes, so the initial state is a constant.
    localparam logic [63:0] HLL_H_INIT = HLL_SEED ^ (HLL_MULT << 3);

    localparam int HLL_MIN_PREC = 8;
    localparam int HLL_MAX_PREC = 14;

    localparam int HLL_VALUE_W = 64;
    localparam int HLL_INDEX_W = 14;
    localparam int HLL_RANK_W  = 6;
    localparam int HLL_REQ_W   = 2;

    localparam logic [HLL_REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [HLL_REQ_W-1:0] REQ_MERGE  = 2'd1;
    localparam logic [HLL_REQ_W-1:0] REQ_READ   = 2'd2;

endpackage

`default_nettype wire

[rtl/hll_hash.sv]
`default_nettype none

module hll_hash
    import hll_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [HLL_VALUE_W-1:0] value,
    output logic                        done,
    output logic [63:0]                 hash
);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_PART = 3'b010,
        H_SUM  = 3'b100
    } hstate_t;

    hstate_t     state_reg;
    hstate_t     state_next;
    logic [1:0]  pass_reg;
    logic [1:0]  pass_next;
    logic [63:0] operand_reg;
    logic [63:0] operand_next;
    logic [63:0] pp0_reg;
    logic [31:0] pp1_reg;
    logic [31:0] pp2_reg;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic        done_reg;
    logic        done_next;
    logic [63:0] prod;
    logic [63:0] prod_xs;
    logic [31:0] cross_prod_lo;
    logic [31:0] cross_prod_hi;

    // Product modulo 2^64 from three 32x32 partial products.
    assign prod    = pp0_reg + {pp1_reg + pp2_reg, 32'd0};
    assign prod_xs = prod ^ (prod >> HLL_SHIFT);

    // Only the low halves of the cross products reach the upper word.
    assign cross_prod_lo = operand_reg[31:0] * HLL_MULT[63:32];
    assign cross_prod_hi = operand_reg[63:32] * HLL_MULT[31:0];

    always_ff @(posedge clk)
    begin
        pp0_reg <= operand_reg[31:0] * HLL_MULT[31:0];
        pp1_reg <= cross_prod_lo;
        pp2_reg <= cross_prod_hi;
    end

    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        operand_next = operand_reg;
        hash_next    = hash_reg;
        done_next    = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    operand_next = value;
                    pass_next    = 2'd0;
                    state_next   = H_PART;
                end
            end
            H_PART:
            begin
                state_next = H_SUM;
            end
            H_SUM:
            begin
                pass_next  = pass_reg + 2'd1;
                state_next = H_PART;
                case (pass_reg)
                    2'd0:    operand_next = prod_xs;
                    2'd1:    operand_next = prod ^ HLL_H_INIT;
                    2'd2:    operand_next = prod_xs;
                    default:
                    begin
                        hash_next  = prod_xs;
                        done_next  = 1'b1;
                        state_next = H_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            pass_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        operand_reg <= operand_next;
        hash_reg    <= hash_next;
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule

`default_nettype wire

[rtl/hll_sketch_insert_core.sv]
// HyperLogLog register file with hashed insert, max-merge and register read.
//
// Items arrive on the s_* stream: s_tuser carries the request kind (insert,
// merge, read; code 3 reads), s_tdata the value, register index and merge
// rank. Every accepted beat produces exactly one result beat on m_* with the
// touched index, the rank held after the operation and a changed flag. The
// register count is 2^precision, set through the APB port at address 0; the
// user must write configuration only while idle; the block does not check it.
//
// One item is worked on at a time. An insert runs the value through the
// iterative hash unit (four 64-bit multiplies, each over the H_PART and
// H_SUM states), then reads, updates and writes back the rank memory; the
// next beat is taken only after the result is loaded. Merge and read skip
// the hash and go straight to the memory lookup.
// The rank memory has one read and one write port and a registered read;
// the read-compare-write sequence runs through the LOOKUP and MODIFY states.
//
// After reset the block clears all 2^MAX_PRECISION entries of the rank memory
// (16384 at the default), one entry a cycle, with s_tready low.
// The result sits in an output register; a new beat is accepted while it
// waits, but the following result is held until m_tready takes the first.
`default_nettype none

module hll_sketch_insert_core
    import hll_pkg::*;
#(
    parameter int MAX_PRECISION = HLL_MAX_PREC
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // value [63:0], reg_index [77:64], merge_rank [83:78], zero [87:84]
    input  wire logic [87:0] s_tdata,
    // req_type [1:0]
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // touched_index [13:0], stored_rank [19:14], changed [20], zero [23:21]
    output logic      [23:0] m_tdata
);

    localparam int IW    = MAX_PRECISION;
    localparam int DEPTH = 1 << IW;
    localparam int WIDE  = (IW > HLL_INDEX_W) ? IW : HLL_INDEX_W;

    localparam logic REG_PRECISION = 1'b0;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_HASH   = 5'b00100,
        ST_LOOKUP = 5'b01000,
        ST_MODIFY = 5'b10000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [IW-1:0]          clr_cnt_reg;
    logic [3:0]             prec_reg;
    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          idx_next;
    logic [HLL_RANK_W-1:0]  rank_reg;
    logic [HLL_RANK_W-1:0]  rank_next;
    logic                   wr_req_reg;
    logic                   wr_req_next;
    logic [HLL_RANK_W-1:0]  rdata_reg;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [HLL_INDEX_W-1:0] out_index_reg;
    logic [HLL_RANK_W-1:0]  out_rank_reg;
    logic                   out_changed_reg;

    logic [HLL_RANK_W-1:0]  mem [DEPTH];

    logic                   cfg_wr;
    logic [4:0]             eff_p;
    logic [4:0]             idx_shift;
    logic [IW-1:0]          idx_mask;
    logic [WIDE-1:0]        ri_ext;
    logic [IW-1:0]          in_idx;
    logic                   in_accept;
    logic                   hash_start;
    logic                   hash_done;
    logic [63:0]            hash;
    logic [IW-1:0]          hash_idx;
    logic [6:0]             tz;
    logic [6:0]             rank_raw;
    logic [6:0]             rank_cap;
    logic [HLL_RANK_W-1:0]  hash_rank;
    logic                   raise;
    logic [HLL_RANK_W-1:0]  new_rank;
    logic                   commit;
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [HLL_RANK_W-1:0]  mem_wdata;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PRECISION);
    assign prdata = (paddr[2] == REG_PRECISION) ? {28'd0, prec_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prec_reg <= 4'(HLL_MIN_PREC);
        end
        else if (cfg_wr)
        begin
            prec_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        if ({1'b0, prec_reg} < 5'(HLL_MIN_PREC))
        begin
            eff_p = 5'(HLL_MIN_PREC);
        end
        else if ({1'b0, prec_reg} > 5'(IW))
        begin
            eff_p = 5'(IW);
        end
        else
        begin
            eff_p = {1'b0, prec_reg};
        end
    end

    assign idx_shift = 5'(IW) - eff_p;
    assign idx_mask  = {IW{1'b1}} >> idx_shift;

    // Index of a merge or read: the given index wrapped to the register count.
    assign ri_ext = WIDE'(s_tdata[77:64]);
    assign in_idx = IW'(ri_ext) & idx_mask;

    assign in_accept  = s_tvalid && s_tready;
    assign hash_start = in_accept && (s_tuser == REQ_INSERT);

    hll_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .value (s_tdata[63:0]),
        .done  (hash_done),
        .hash  (hash)
    );

    // The top precision bits of the hash select the register.
    assign hash_idx = hash[63 -: IW] >> idx_shift;

    always_comb
    begin
        tz = 7'd64;
        for (int i = 63; i >= 0; i--)
        begin
            if (hash[i])
            begin
                tz = 7'(i);
            end
        end
    end

    assign rank_raw  = tz + 7'd1;
    assign rank_cap  = 7'd64 - {2'b00, eff_p};
    assign hash_rank = (hash == 64'd0) ? '0
                     : HLL_RANK_W'((rank_raw < rank_cap) ? rank_raw : rank_cap);

    assign raise    = wr_req_reg && (rank_reg > rdata_reg);
    assign new_rank = raise ? rank_reg : rdata_reg;
    assign commit   = (state_reg == ST_MODIFY) && (!m_tvalid_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        rank_next   = rank_reg;
        wr_req_next = wr_req_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == {IW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next = in_idx;
                    case (s_tuser)
                        REQ_INSERT:
                        begin
                            wr_req_next = 1'b1;
                            state_next  = ST_HASH;
                        end
                        REQ_MERGE:
                        begin
                            rank_next   = s_tdata[83:78];
                            wr_req_next = 1'b1;
                            state_next  = ST_LOOKUP;
                        end
                        default:
                        begin
                            wr_req_next = 1'b0;
                            state_next  = ST_LOOKUP;
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = hash_idx;
                    rank_next  = hash_rank;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rank_reg   <= rank_next;
        wr_req_reg <= wr_req_next;
        if (commit)
        begin
            out_index_reg   <= HLL_INDEX_W'(WIDE'(idx_reg));
            out_rank_reg    <= new_rank;
            out_changed_reg <= raise;
        end
    end

    // Rank memory: the clearing sweep and the write-back share the write port.
    assign mem_we    = (state_reg == ST_CLEAR) || (commit && raise);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : rank_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, out_changed_reg, out_rank_reg, out_index_reg};

    // The hash unit only finishes while the controller waits for it.
    a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == ST_HASH))
        else $error("hash finished outside the hash wait state");

    // A raised register never reports rank zero.
    a_changed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[20]) |-> (m_tdata[19:14] != '0))
        else $error("changed result with zero rank");

    // The clearing sweep ends in idle once the last entry is written.
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CLEAR) && (clr_cnt_reg == {IW{1'b1}})) |=> (state_reg == ST_IDLE))
        else $error("clearing pass did not end in idle");

    // A result is loaded only after the memory read of the same item.
    a_commit_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_MODIFY) |-> $past(state_reg == ST_LOOKUP))
        else $error("modify entered without a lookup");

endmodule

`default_nettype wire
